>>> hdl/bca_pkg.sv
// Package of the bank context allocator: transaction payload types, request codes
// and the control bundles passed between the allocator's submodules.
// No dependencies; every other file of the block imports it.
package bca_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP  = 2'd2;

    // Widest context and bank indices that the parameter ranges allow.
    localparam int SLICE_MAX_W = 5;
    localparam int BANK_MAX_W  = 8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        rd_waiting;
        logic        wr_waiting;
        logic [5:0]  rd_bank;
        logic [5:0]  wr_bank;
        logic        rd_overdue;
        logic        wr_overdue;
        logic        write_critical;
        logic        low_read_critical;
        logic        high_read_critical;
        logic [15:0] idle_mask;
        logic [5:0]  lookup_bank;
    } bca_req_t;

    typedef struct packed {
        logic       op_done;
        logic [3:0] slice;
        logic [5:0] bank;
        logic       is_read;
        logic [4:0] free_count;
    } bca_rsp_t;

    // Free list control: pop the head or push a released context.
    typedef struct packed {
        logic                   pop;
        logic                   push;
        logic [SLICE_MAX_W-1:0] push_idx;
    } fl_ctrl_t;

    // Bank map control: one registered read and one write per cycle.
    typedef struct packed {
        logic                   rd_en;
        logic [BANK_MAX_W-1:0]  rd_addr;
        logic                   wr_en;
        logic                   wr_set;
        logic [BANK_MAX_W-1:0]  wr_addr;
        logic [SLICE_MAX_W-1:0] wr_slice;
    } map_ctrl_t;

endpackage

>>> hdl/bca_if.sv
// Handshake interfaces of the bank context allocator: request and response channels.
// Each carries valid, ready and a payload struct; depends on bca_pkg.
interface bca_req_if import bca_pkg::*; ();
    logic     valid;
    logic     ready;
    bca_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bca_rsp_if import bca_pkg::*; ();
    logic     valid;
    logic     ready;
    bca_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/bca_free_list.sv
// Free list of context indices: a circular FIFO held in a synchronous memory.
// Depends on bca_pkg for the control bundle.
module bca_free_list import bca_pkg::*; #(
    parameter int SLICES = 16,
    localparam int SW = $clog2(SLICES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fl_ctrl_t      ctrl,
    output logic [SW-1:0] head_idx,
    output logic [SW:0]   level
);

    logic [SW-1:0] mem [SLICES];
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [SW:0]   level_reg, level_next;
    logic [SW:0]   fill_reg, fill_next;
    logic [SW-1:0] rd_data_reg;
    logic [SW-1:0] rd_addr_reg;
    logic          rd_fresh_reg;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
        logic [SW-1:0] r;
        r = (p == SW'(SLICES - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // The first SLICES pushes land on entries 0, 1, 2 ... in order, so an entry
    // at or above the fill count has never been written, and the read returns its
    // own index in place of the memory contents.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.push_idx[SW-1:0];
        end
        rd_data_reg  <= mem[head_reg];
        rd_addr_reg  <= head_reg;
        rd_fresh_reg <= ({1'b0, head_reg} >= fill_reg);
    end

    assign head_idx = rd_fresh_reg ? rd_addr_reg : rd_data_reg;
    assign level    = level_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        fill_next  = fill_reg;
        if (ctrl.pop)
        begin
            head_next  = wrap_inc(head_reg);
            level_next = level_reg - 1'b1;
        end
        else if (ctrl.push)
        begin
            tail_next  = wrap_inc(tail_reg);
            level_next = level_reg + 1'b1;
            if (fill_reg != (SW+1)'(SLICES))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= (SW+1)'(SLICES);
            fill_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

>>> hdl/bca_bank_map.sv
// Bank-to-context map: a synchronous memory of context indices with a valid bit
// per bank in flip-flops. Depends on bca_pkg for the control bundle.
module bca_bank_map import bca_pkg::*; #(
    parameter int BANKS = 64,
    parameter int SLICES = 16,
    localparam int BW = $clog2(BANKS),
    localparam int SW = $clog2(SLICES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  map_ctrl_t     ctrl,
    output logic          rd_hit,
    output logic [SW-1:0] rd_slice
);

    logic [SW-1:0]    mem [BANKS];
    logic [BANKS-1:0] valid_reg;
    logic             rd_hit_reg;
    logic [SW-1:0]    rd_slice_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_set)
        begin
            mem[ctrl.wr_addr[BW-1:0]] <= ctrl.wr_slice[SW-1:0];
        end
        if (ctrl.rd_en)
        begin
            rd_slice_reg <= mem[ctrl.rd_addr[BW-1:0]];
            rd_hit_reg   <= valid_reg[ctrl.rd_addr[BW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_reg[ctrl.wr_addr[BW-1:0]] <= ctrl.wr_set;
        end
    end

    assign rd_hit   = rd_hit_reg;
    assign rd_slice = rd_slice_reg;

endmodule

>>> hdl/bank_context_allocator_top.sv
// Bank context allocator top level: request decode, direction choice, release
// picker, context-to-bank memory and the result register.
// Depends on bca_pkg, bca_if, bca_free_list and bca_bank_map.
// An accepted request is registered; the result register is loaded when the execute
// state fires, which waits while an earlier result is unaccepted. Requests are taken
// only in the idle state; the memories are read at accept and written back at the fire.
// Reset clears the pointers, the allocated set and the bank map valid bits; the free
// list reads as indices 0 upward through a fill count, so no clearing pass is needed.
module bank_context_allocator_top import bca_pkg::*; #(
    parameter int SLICES = 16,
    parameter int BANKS = 64
) (
    input logic      clk,
    input logic      rst_n,
    bca_req_if.sink  req,
    bca_rsp_if.source rsp
);

    localparam int SW = $clog2(SLICES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic [1:0]    req_type;
        logic          take_rd;
        logic          any_wait;
        logic [5:0]    bank;
        logic          bank_ok;
        logic [5:0]    lookup_bank;
        logic          lookup_ok;
        logic          cand_any;
        logic [SW-1:0] pick;
    } item_t;

    state_t        state_reg, state_next;
    item_t         item_reg, item_next;
    logic [SLICES-1:0] alloc_reg, alloc_next;
    logic [SW-1:0] last_reg, last_next;
    logic          out_valid_reg, out_valid_next;
    bca_rsp_t      out_data_reg, out_data_next;

    logic [5:0]    sb_mem [SLICES];
    logic [5:0]    sb_rd_reg;

    fl_ctrl_t      fl_ctrl;
    map_ctrl_t     map_ctrl;
    logic [SW-1:0] head_idx;
    logic [SW:0]   level;
    logic          map_hit;
    logic [SW-1:0] map_slice;

    logic          accept;
    logic          fire;
    logic [SLICES-1:0] cand;
    logic [SLICES-1:0] ge_mask;
    logic          alloc_ok;
    logic          rel_ok;
    logic          rel_bank_ok;
    logic          lk_hit;
    logic [SW:0]   level_after;
    logic [SW-1:0] res_slice;
    logic [31:0]   slice_wide;
    logic [31:0]   level_wide;

    function automatic logic [SW-1:0] lowest_set(input logic [SLICES-1:0] v);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = SLICES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SW'(i);
            end
        end
        return idx;
    endfunction

    bca_free_list #(.SLICES(SLICES)) u_free_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fl_ctrl),
        .head_idx (head_idx),
        .level    (level)
    );

    bca_bank_map #(.BANKS(BANKS), .SLICES(SLICES)) u_bank_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (map_ctrl),
        .rd_hit   (map_hit),
        .rd_slice (map_slice)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    // Decode of the incoming transaction: direction choice and release pick.
    always_comb
    begin
        cand = SLICES'(req.data.idle_mask) & alloc_reg;
        for (int i = 0; i < SLICES; i++)
        begin
            ge_mask[i] = (SW'(i) >= last_reg);
        end

        item_next.req_type = req.data.req_type;
        item_next.any_wait = req.data.rd_waiting || req.data.wr_waiting;
        if (!req.data.wr_waiting)
        begin
            item_next.take_rd = 1'b1;
        end
        else if (!req.data.rd_waiting)
        begin
            item_next.take_rd = 1'b0;
        end
        else if (req.data.rd_overdue)
        begin
            item_next.take_rd = 1'b1;
        end
        else if (req.data.wr_overdue)
        begin
            item_next.take_rd = 1'b0;
        end
        else
        begin
            item_next.take_rd = !req.data.write_critical || req.data.low_read_critical ||
                                req.data.high_read_critical;
        end
        item_next.bank        = item_next.take_rd ? req.data.rd_bank : req.data.wr_bank;
        item_next.bank_ok     = (32'(item_next.bank) < BANKS);
        item_next.lookup_bank = req.data.lookup_bank;
        item_next.lookup_ok   = (32'(req.data.lookup_bank) < BANKS);
        item_next.cand_any    = (cand != '0);
        item_next.pick        = ((cand & ge_mask) != '0) ? lowest_set(cand & ge_mask)
                                                         : lowest_set(cand);
    end

    // Execute: results of the memory reads issued at accept decide the outcome.
    always_comb
    begin
        alloc_ok    = (item_reg.req_type == REQ_ALLOC) && item_reg.any_wait &&
                      (level != '0) && item_reg.bank_ok && !map_hit;
        rel_ok      = (item_reg.req_type == REQ_RELEASE) && item_reg.cand_any;
        rel_bank_ok = (32'(sb_rd_reg) < BANKS);
        lk_hit      = item_reg.lookup_ok && map_hit;

        level_after = level;
        if (alloc_ok)
        begin
            level_after = level - 1'b1;
        end
        else if (rel_ok)
        begin
            level_after = level + 1'b1;
        end

        out_data_next = '0;
        res_slice     = '0;
        case (item_reg.req_type)
            REQ_ALLOC:
            begin
                if (alloc_ok)
                begin
                    out_data_next.op_done = 1'b1;
                    out_data_next.bank    = item_reg.bank;
                    out_data_next.is_read = item_reg.take_rd;
                    res_slice             = head_idx;
                end
            end
            REQ_RELEASE:
            begin
                if (rel_ok)
                begin
                    out_data_next.op_done = 1'b1;
                    out_data_next.bank    = sb_rd_reg;
                    res_slice             = item_reg.pick;
                end
            end
            REQ_LOOKUP:
            begin
                out_data_next.op_done = lk_hit;
                out_data_next.bank    = item_reg.lookup_bank;
                if (lk_hit)
                begin
                    res_slice = map_slice;
                end
            end
            default:
            begin
                out_data_next.op_done = 1'b0;
            end
        endcase
        slice_wide               = 32'(res_slice);
        level_wide               = 32'(level_after);
        out_data_next.slice      = slice_wide[3:0];
        out_data_next.free_count = level_wide[4:0];
    end

    always_comb
    begin
        fl_ctrl.pop      = fire && alloc_ok;
        fl_ctrl.push     = fire && rel_ok;
        fl_ctrl.push_idx = SLICE_MAX_W'(item_reg.pick);

        map_ctrl.rd_en    = accept;
        map_ctrl.rd_addr  = (req.data.req_type == REQ_LOOKUP) ?
                            BANK_MAX_W'(req.data.lookup_bank) : BANK_MAX_W'(item_next.bank);
        map_ctrl.wr_en    = fire && (alloc_ok || (rel_ok && rel_bank_ok));
        map_ctrl.wr_set   = alloc_ok;
        map_ctrl.wr_addr  = alloc_ok ? BANK_MAX_W'(item_reg.bank) : BANK_MAX_W'(sb_rd_reg);
        map_ctrl.wr_slice = SLICE_MAX_W'(head_idx);
    end

    // Accesses never overlap on one entry: reads happen at accept, writes at the
    // execute cycle, and the next transaction is only accepted after the write.
    always_ff @(posedge clk)
    begin
        if (fire && alloc_ok)
        begin
            sb_mem[head_idx] <= item_reg.bank;
        end
        if (accept)
        begin
            sb_rd_reg <= sb_mem[item_next.pick];
            item_reg  <= item_next;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        alloc_next     = alloc_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (alloc_ok)
                    begin
                        alloc_next[head_idx] = 1'b1;
                    end
                    else if (rel_ok)
                    begin
                        alloc_next[item_reg.pick] = 1'b0;
                        last_next                 = item_reg.pick;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Every context is either on the free list or in the allocated set.
    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(alloc_reg) + int'(level)) == SLICES)
        else $error("free level and allocated set disagree");

    a_alloc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && alloc_ok) |-> !alloc_reg[head_idx])
        else $error("free list handed out an allocated context");

    a_release_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rel_ok) |-> alloc_reg[item_reg.pick])
        else $error("release picked a context that is not allocated");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("executed transaction produced no result");

endmodule

>>> bench/bank_context_allocator_top_test.sv
// Testbench of the bank context allocator: a clocked driver feeds request transactions
// from a queue, a clocked monitor checks every response against a built-in predictor.
// Depends on bca_pkg, bca_if and bank_context_allocator_top.
`timescale 1ns / 100ps

module bank_context_allocator_top_test;
    import bca_pkg::*;

    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLDOFF_CYCLES = 300;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_t;

    logic clk;
    logic rst_n;

    bca_req_if req_ch ();
    bca_rsp_if rsp_ch ();

    bank_context_allocator_top #(.SLICES(16), .BANKS(64)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted state of the context pool.
    logic [3:0] free_list [16];
    logic [3:0] fl_head;
    logic [3:0] fl_tail;
    logic [4:0] fl_level;
    logic [15:0] alloc_set;
    logic [5:0] ctx_bank [16];
    logic       map_valid [64];
    logic [3:0] map_ctx [64];
    logic [3:0] rr_last;

    bca_req_t pending_req_q [$];
    bca_rsp_t expected_rsp_q [$];
    logic [5:0] recent_banks [$];

    phase_t cur_phase;
    int     error_count;
    int     cycle_count;
    int     holdoff_left;
    bit     holdoff_used;

    function automatic void enqueue_req(bca_req_t r);
        pending_req_q = {pending_req_q, r};
    endfunction

    function automatic bca_rsp_t predict_response(bca_req_t r);
        bca_rsp_t o;
        logic take_rd;
        logic [5:0] b;
        logic [3:0] s;
        logic [15:0] cand;
        int pick;
        int i;
        o = '0;
        case (r.req_type)
            REQ_ALLOC:
            begin
                if (r.rd_waiting || r.wr_waiting)
                begin
                    if (!r.wr_waiting)
                        take_rd = 1'b1;
                    else if (!r.rd_waiting)
                        take_rd = 1'b0;
                    else if (r.rd_overdue)
                        take_rd = 1'b1;
                    else if (r.wr_overdue)
                        take_rd = 1'b0;
                    else
                        take_rd = !r.write_critical || r.low_read_critical
                                  || r.high_read_critical;
                    b = take_rd ? r.rd_bank : r.wr_bank;
                    if (fl_level != 0 && !map_valid[b])
                    begin
                        s = free_list[fl_head];
                        fl_head = fl_head + 4'd1;
                        fl_level = fl_level - 5'd1;
                        alloc_set[s] = 1'b1;
                        ctx_bank[s] = b;
                        map_valid[b] = 1'b1;
                        map_ctx[b] = s;
                        o.op_done = 1'b1;
                        o.slice = s;
                        o.bank = b;
                        o.is_read = take_rd;
                    end
                end
            end
            REQ_RELEASE:
            begin
                cand = r.idle_mask & alloc_set;
                if (cand != 16'd0)
                begin
                    pick = -1;
                    // Round robin: first candidate from the last released index upward.
                    for (i = rr_last; i < 16; i++)
                        if (pick < 0 && cand[i])
                            pick = i;
                    for (i = 0; i < 16; i++)
                        if (pick < 0 && cand[i])
                            pick = i;
                    s = pick[3:0];
                    rr_last = s;
                    b = ctx_bank[s];
                    map_valid[b] = 1'b0;
                    alloc_set[s] = 1'b0;
                    free_list[fl_tail] = s;
                    fl_tail = fl_tail + 4'd1;
                    fl_level = fl_level + 5'd1;
                    o.op_done = 1'b1;
                    o.slice = s;
                    o.bank = b;
                end
            end
            REQ_LOOKUP:
            begin
                o.bank = r.lookup_bank;
                if (map_valid[r.lookup_bank])
                begin
                    o.op_done = 1'b1;
                    o.slice = map_ctx[r.lookup_bank];
                end
            end
            default:
                ;
        endcase
        o.free_count = fl_level;
        return o;
    endfunction

    function automatic bca_req_t alloc_req(logic rdw, logic wrw, logic [5:0] rdb,
                                           logic [5:0] wrb, logic rdu, logic wru,
                                           logic wc, logic lc, logic hc);
        bca_req_t r;
        r = '0;
        r.req_type = REQ_ALLOC;
        r.rd_waiting = rdw;
        r.wr_waiting = wrw;
        r.rd_bank = rdb;
        r.wr_bank = wrb;
        r.rd_overdue = rdu;
        r.wr_overdue = wru;
        r.write_critical = wc;
        r.low_read_critical = lc;
        r.high_read_critical = hc;
        return r;
    endfunction

    function automatic bca_req_t release_req(logic [15:0] mask);
        bca_req_t r;
        r = '0;
        r.req_type = REQ_RELEASE;
        r.idle_mask = mask;
        return r;
    endfunction

    function automatic bca_req_t lookup_req(logic [5:0] bank);
        bca_req_t r;
        r = '0;
        r.req_type = REQ_LOOKUP;
        r.lookup_bank = bank;
        return r;
    endfunction

    // Random request; fields the operation ignores still carry random bits.
    function automatic bca_req_t random_req(int mode);
        bca_req_t r;
        logic [63:0] raw;
        int pick;
        int alloc_w;
        int rel_w;
        raw = {$urandom, $urandom};
        r = raw[$bits(bca_req_t)-1:0];
        case (mode)
            0: begin alloc_w = 60; rel_w = 20; end
            1: begin alloc_w = 15; rel_w = 60; end
            default: begin alloc_w = 35; rel_w = 30; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < alloc_w)
        begin
            r.req_type = REQ_ALLOC;
            r.rd_waiting = ($urandom_range(0, 3) != 0);
            r.wr_waiting = ($urandom_range(0, 3) != 0);
            r.rd_overdue = ($urandom_range(0, 9) < 3);
            r.wr_overdue = ($urandom_range(0, 9) < 3);
            // Some allocations aim at a bank that is probably mapped already.
            if (recent_banks.size() > 0 && $urandom_range(0, 3) == 0)
                r.rd_bank = recent_banks[$urandom_range(0, recent_banks.size() - 1)];
            if (recent_banks.size() > 0 && $urandom_range(0, 3) == 0)
                r.wr_bank = recent_banks[$urandom_range(0, recent_banks.size() - 1)];
            recent_banks = {recent_banks, r.rd_bank};
            recent_banks = {recent_banks, r.wr_bank};
            while (recent_banks.size() > 24)
                recent_banks.delete(0);
        end
        else if (pick < alloc_w + rel_w)
        begin
            r.req_type = REQ_RELEASE;
            case ($urandom_range(0, 9))
                0, 1, 2: r.idle_mask = 16'($urandom | $urandom);
                3, 4: r.idle_mask = 16'($urandom & $urandom & $urandom);
                default: r.idle_mask = 16'($urandom);
            endcase
        end
        else if (pick < 95)
        begin
            r.req_type = REQ_LOOKUP;
            if (recent_banks.size() > 0 && $urandom_range(0, 9) < 7)
                r.lookup_bank = recent_banks[$urandom_range(0, recent_banks.size() - 1)];
        end
        else
            r.req_type = REQ_NOP;
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Request driver: holds an offered transaction until it is taken.
    always @(posedge clk)
    begin : drive_req
        logic offer_next;
        int offer_pct;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_rsp_q = {expected_rsp_q, predict_response(req_ch.data)};
            case (cur_phase)
                PH_SEND_IDLE: offer_pct = 20;
                PH_BOTH: offer_pct = 78;
                default: offer_pct = 100;
            endcase
            if (req_ch.valid && !req_ch.ready)
                offer_next = 1'b1;
            else if (pending_req_q.size() > 0 && $urandom_range(0, 99) < offer_pct)
            begin
                offer_next = 1'b1;
                req_ch.data <= pending_req_q[0];
                pending_req_q.delete(0);
            end
            else
                offer_next = 1'b0;
            req_ch.valid <= offer_next;
        end
    end

    // A single long hold-off of the receiver lets the block fill and push back on requests.
    always @(posedge clk)
    begin : hold_off
        if (rst_n)
        begin
            if (cur_phase == PH_PRESSURE && !holdoff_used)
            begin
                holdoff_used <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
            end
            else if (holdoff_left > 0)
                holdoff_left <= holdoff_left - 1;
        end
    end

    // Response monitor and receiver.
    always @(posedge clk)
    begin : watch_rsp
        bca_rsp_t exp_rsp;
        logic ready_next;
        int ready_pct;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: response with none expected, actual %h", $time,
                             rsp_ch.data);
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp_q[0];
                    expected_rsp_q.delete(0);
                    check_field("op_done", exp_rsp.op_done, rsp_ch.data.op_done);
                    check_field("slice", exp_rsp.slice, rsp_ch.data.slice);
                    check_field("bank", exp_rsp.bank, rsp_ch.data.bank);
                    check_field("is_read", exp_rsp.is_read, rsp_ch.data.is_read);
                    check_field("free_count", exp_rsp.free_count, rsp_ch.data.free_count);
                end
            end
            case (cur_phase)
                PH_RECV_STALL: ready_pct = 20;
                PH_BOTH: ready_pct = 78;
                default: ready_pct = 100;
            endcase
            if (holdoff_left > 0)
                ready_next = 1'b0;
            else
                ready_next = ($urandom_range(0, 99) < ready_pct);
            rsp_ch.ready <= ready_next;
        end
    end

    initial
    begin : stimulus
        int i;
        int p;
        int mode;
        phase_t plan [6];
        int plan_items [6];
        for (i = 0; i < 16; i++)
        begin
            free_list[i] = i[3:0];
            ctx_bank[i] = 6'd0;
        end
        for (i = 0; i < 64; i++)
        begin
            map_valid[i] = 1'b0;
            map_ctx[i] = 4'd0;
        end
        fl_head = 4'd0;
        fl_tail = 4'd0;
        fl_level = 5'd16;
        alloc_set = 16'd0;
        rr_last = 4'd0;
        error_count = 0;
        cycle_count = 0;
        holdoff_left = 0;
        holdoff_used = 1'b0;
        cur_phase = PH_FREE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty pool: lookup miss, release with nothing allocated, nothing waiting.
        enqueue_req(lookup_req(6'd0));
        enqueue_req(release_req(16'hFFFF));
        enqueue_req(alloc_req(0, 0, 6'd1, 6'd2, 1, 1, 1, 1, 1));
        // Direction choice in each of its cases.
        enqueue_req(alloc_req(1, 0, 6'd0, 6'd1, 0, 1, 1, 0, 0));
        enqueue_req(alloc_req(0, 1, 6'd2, 6'd63, 1, 0, 0, 1, 1));
        enqueue_req(alloc_req(1, 1, 6'd5, 6'd6, 1, 1, 1, 0, 0));
        enqueue_req(alloc_req(1, 1, 6'd8, 6'd7, 0, 1, 0, 1, 1));
        enqueue_req(alloc_req(1, 1, 6'd13, 6'd9, 0, 0, 1, 0, 0));
        enqueue_req(alloc_req(1, 1, 6'd10, 6'd14, 0, 0, 1, 1, 0));
        enqueue_req(alloc_req(1, 1, 6'd11, 6'd15, 0, 0, 1, 0, 1));
        enqueue_req(alloc_req(1, 1, 6'd12, 6'd16, 0, 0, 0, 0, 0));
        // Bank already mapped.
        enqueue_req(alloc_req(1, 0, 6'd0, 6'd40, 0, 0, 0, 0, 0));
        enqueue_req(lookup_req(6'd63));
        enqueue_req(lookup_req(6'd62));
        // Releases: no idle candidate, then round-robin picks.
        enqueue_req(release_req(16'h0000));
        enqueue_req(release_req(16'hFFFF));
        enqueue_req(release_req(16'hFFFF));
        // Fill the pool, then an allocation with no free context.
        for (i = 0; i < 10; i++)
            enqueue_req(alloc_req(0, 1, 6'd0, 6'd20 + i[5:0], 0, 0, 0, 0, 0));
        enqueue_req(alloc_req(1, 1, 6'd30, 6'd31, 0, 0, 0, 0, 0));

        plan[0] = PH_FREE;       plan_items[0] = 300;
        plan[1] = PH_SEND_IDLE;  plan_items[1] = 300;
        plan[2] = PH_RECV_STALL; plan_items[2] = 300;
        plan[3] = PH_BOTH;       plan_items[3] = 400;
        plan[4] = PH_PRESSURE;   plan_items[4] = 100;
        plan[5] = PH_FREE;       plan_items[5] = 300;

        mode = 2;
        for (p = 0; p < 6; p++)
        begin
            while (pending_req_q.size() > 0 || req_ch.valid || expected_rsp_q.size() > 0)
                @(negedge clk);
            cur_phase = plan[p];
            for (i = 0; i < plan_items[p]; i++)
            begin
                // Each burst leans towards allocation or release, or mixes both, to reach a full and an empty pool.
                if (i % 32 == 0)
                    mode = $urandom_range(0, 2);
                enqueue_req(random_req(mode));
            end
        end

        while (pending_req_q.size() > 0 || req_ch.valid || expected_rsp_q.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (expected_rsp_q.size() > 0)
        begin
            $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> bank_context_allocator_top.f
hdl/bca_pkg.sv
hdl/bca_if.sv
hdl/bca_free_list.sv
hdl/bca_bank_map.sv
hdl/bank_context_allocator_top.sv
bench/bank_context_allocator_top_test.sv
